// ===== src/ufbf_pkg.sv =====
// ----------------------------------------------------------------------------
// ufbf_pkg
// Shared constants, types and codes of the UF2 block framer.
// ----------------------------------------------------------------------------
package ufbf_pkg;

    // block layout
    localparam int BLOCK_WORDS         = 64;
    localparam int HEADER_WORDS        = 4;
    localparam int FLUSH_WORDS         = BLOCK_WORDS - HEADER_WORDS;
    localparam int CNT_W               = $clog2(BLOCK_WORDS);
    localparam int UFBF_PAYLOAD_BYTES  = 256;

    localparam logic [31:0] MAGIC_START0 = 32'h0A32_4655;
    localparam logic [31:0] MAGIC_START1 = 32'h9E5D_5157;
    localparam logic [31:0] MAGIC_END    = 32'h0AB1_6F30;
    localparam logic [31:0] FLAG_FAMILY  = 32'h0000_2000;

    // configuration register indexes and reset values
    localparam logic [1:0]  CFG_BASE_ADDRESS    = 2'd0;
    localparam logic [1:0]  CFG_FAMILY_ID       = 2'd1;
    localparam logic [1:0]  CFG_FILE_SIZE_BYTES = 2'd2;
    localparam logic [31:0] BASE_ADDRESS_RESET  = 32'h0801_0000;
    localparam logic [31:0] FAMILY_ID_RESET     = 32'h5775_5A57;

    typedef enum logic [1:0] {
        JOB_IDLE,
        JOB_HEADER,
        JOB_FLUSH
    } ufbf_job_t;

    // work handed from the input side to the output sequencer
    typedef struct packed {
        logic             hdr;
        logic             flush;
        logic [31:0]      addr;
        logic [23:0]      num;
        logic [CNT_W-1:0] count;
        logic             bank;
        logic             eof;
    } ufbf_req_t;

endpackage

// ===== src/ufbf_ram.sv =====
// ----------------------------------------------------------------------------
// ufbf_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ufbf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ufbf_seq.sv =====
// ----------------------------------------------------------------------------
// ufbf_seq
// Output sequencer: queues header and flush jobs, walks them word by word
// through a read stage and the output register.
// ----------------------------------------------------------------------------
module ufbf_seq
    import ufbf_pkg::*;
#(
    parameter int PAYLOAD_BYTES = UFBF_PAYLOAD_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  ufbf_req_t   req,
    input  logic [31:0] family_id,
    input  logic [31:0] total,
    output logic        flush_busy,
    output logic        ram_re,
    output logic [((PAYLOAD_BYTES / 8 > 1) ? $clog2(PAYLOAD_BYTES / 8) : 1):0] ram_raddr,
    input  logic [63:0] ram_rdata,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] block_word,
    output logic        block_end,
    output logic        stream_end
);

    localparam int PAYLOAD_WORDS = PAYLOAD_BYTES / 8;
    localparam int IDX_W = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;

    ufbf_job_t        state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             hdr_pend_reg, hdr_pend_next;
    logic             fl_pend_reg, fl_pend_next;

    // header snapshot
    logic [31:0]      hd_addr_reg;
    logic [23:0]      hd_num_reg;
    // pending and active flush snapshots
    logic [CNT_W-1:0] pf_count_reg, fa_count_reg;
    logic             pf_bank_reg, fa_bank_reg;
    logic             pf_eof_reg, fa_eof_reg;

    // read stage and output register
    logic             s1_valid_reg;
    logic [63:0]      s1_word_reg;
    logic             s1_ram_reg, s1_end_reg, s1_last_reg;
    logic             out_valid_reg;
    logic [63:0]      block_word_reg;
    logic             block_end_reg, stream_end_reg;

    logic             out_free, s1_take, issue, job_done, start_flush;
    logic             job_last;
    logic [63:0]      tok_word;
    logic             tok_ram, tok_end, tok_last;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_take  = !s1_valid_reg || out_free;
    assign issue    = (state_reg != JOB_IDLE) && s1_take;
    assign job_done = (state_reg == JOB_IDLE) || (issue && job_last);
    assign start_flush = job_done && !hdr_pend_reg && fl_pend_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        if (job_done)
        begin
            cnt_next = '0;
            priority if (hdr_pend_reg)
            begin
                state_next = JOB_HEADER;
            end
            else if (fl_pend_reg)
            begin
                state_next = JOB_FLUSH;
            end
            else
            begin
                state_next = JOB_IDLE;
            end
        end
        else if (issue)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        hdr_pend_next = req.hdr || (hdr_pend_reg && !job_done);
        fl_pend_next  = req.flush || (fl_pend_reg && !start_flush);
    end

    // word of the current job
    always_comb
    begin
        tok_word = '0;
        tok_ram  = 1'b0;
        tok_end  = 1'b0;
        tok_last = 1'b0;
        job_last = 1'b0;
        unique case (state_reg)
            JOB_HEADER:
            begin
                job_last = (cnt_reg == CNT_W'(HEADER_WORDS - 1));
                unique case (cnt_reg[1:0])
                    2'd0:    tok_word = {MAGIC_START1, MAGIC_START0};
                    2'd1:    tok_word = {hd_addr_reg, FLAG_FAMILY};
                    2'd2:    tok_word = {8'd0, hd_num_reg, 32'(PAYLOAD_BYTES)};
                    default: tok_word = {family_id, total};
                endcase
            end
            JOB_FLUSH:
            begin
                job_last = (cnt_reg == CNT_W'(FLUSH_WORDS - 1));
                tok_ram  = (cnt_reg < fa_count_reg);
                if (job_last)
                begin
                    tok_word = {MAGIC_END, 32'd0};
                    tok_end  = 1'b1;
                    tok_last = fa_eof_reg;
                end
            end
            default:
            begin
                tok_word = '0;
            end
        endcase
    end

    assign ram_re    = issue;
    assign ram_raddr = {fa_bank_reg, cnt_reg[IDX_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= JOB_IDLE;
            cnt_reg       <= '0;
            hdr_pend_reg  <= 1'b0;
            fl_pend_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            hdr_pend_reg <= hdr_pend_next;
            fl_pend_reg  <= fl_pend_next;
            if (s1_take)
            begin
                s1_valid_reg <= issue;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.hdr)
        begin
            hd_addr_reg <= req.addr;
            hd_num_reg  <= req.num;
        end
        if (req.flush)
        begin
            pf_count_reg <= req.count;
            pf_bank_reg  <= req.bank;
            pf_eof_reg   <= req.eof;
        end
        if (start_flush)
        begin
            fa_count_reg <= pf_count_reg;
            fa_bank_reg  <= pf_bank_reg;
            fa_eof_reg   <= pf_eof_reg;
        end
        if (s1_take)
        begin
            s1_word_reg <= tok_word;
            s1_ram_reg  <= tok_ram;
            s1_end_reg  <= tok_end;
            s1_last_reg <= tok_last;
        end
        if (out_free)
        begin
            block_word_reg <= s1_ram_reg ? ram_rdata : s1_word_reg;
            block_end_reg  <= s1_end_reg;
            stream_end_reg <= s1_last_reg;
        end
    end

    assign flush_busy = fl_pend_reg;
    assign out_valid  = out_valid_reg;
    assign block_word = block_word_reg;
    assign block_end  = block_end_reg;
    assign stream_end = stream_end_reg;

endmodule

// ===== src/uf2_block_framer.sv =====
// ----------------------------------------------------------------------------
// uf2_block_framer
// Packs a firmware image, given as 64-bit little-endian beats, into 512-byte
// UF2 blocks sent as 64 little-endian 64-bit words.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one image beat per accept, with its
// count of valid low bytes and an end-of-file mark. Output channel
// (out_valid / out_stall): block words, block_end on word 64 of each block,
// stream_end on the last word of the block closed by end of file.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): base address,
// family id and file size; cfg_ready is always high. Write only while idle.
// Timing: the first header word of a block passes the header pending flag,
// the job state, the read stage and the output register after the beat that
// opens the block; the remaining 60 words pass the flush pending flag and the
// same stages after the closing beat or the header, whichever is later.
// Throughput: one output word per cycle while a job runs and out_stall is
// low; a 32-beat block gives 64 words. Payload is held in a two-bank buffer,
// so the next block fills while the previous one is read out; in_stall is
// high from a block's closing beat until that block's readout begins, which
// waits while the previous block or this block's header is being read out.
// Reset clears all control state; the stream restarts at the base address
// with block number zero. A stalled receiver backs up the output register
// and the read stage and, through them, the input.
// ----------------------------------------------------------------------------
module uf2_block_framer
    import ufbf_pkg::*;
#(
    parameter int PAYLOAD_BYTES = UFBF_PAYLOAD_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] data_word,
    input  logic [3:0]  valid_bytes,
    input  logic        end_of_file,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] block_word,
    output logic        block_end,
    output logic        stream_end
);

    localparam int PAYLOAD_WORDS = PAYLOAD_BYTES / 8;
    localparam int IDX_W = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
    localparam int RAM_DEPTH = 2 ** (IDX_W + 1);
    // reciprocal for the block total: exact quotient of any 32-bit value
    localparam int DIV_SH = $clog2(PAYLOAD_BYTES);
    localparam longint unsigned DIV_M = ((64'd1 << (32 + DIV_SH)) / PAYLOAD_BYTES) + 1;

    logic [31:0]      base_address_reg, family_id_reg, file_size_reg;
    logic [31:0]      quot_reg;
    logic             fs_zero_reg;
    logic [64:0]      prod;
    logic [31:0]      total;

    logic             started_reg, started_next;
    logic [IDX_W-1:0] idx_reg, idx_next, eff_idx;
    logic             bank_reg, bank_next;
    logic [23:0]      num_reg, num_next, eff_num;
    logic [31:0]      addr_reg, addr_next, eff_addr;
    logic [CNT_W-1:0] count_new;
    logic             accept, close;
    logic [63:0]      word_masked;
    ufbf_req_t        req;

    logic             ram_re;
    logic [IDX_W:0]   ram_raddr;
    logic [63:0]      ram_rdata;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= BASE_ADDRESS_RESET;
            family_id_reg    <= FAMILY_ID_RESET;
            file_size_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BASE_ADDRESS:    base_address_reg <= cfg_data;
                CFG_FAMILY_ID:       family_id_reg    <= cfg_data;
                CFG_FILE_SIZE_BYTES: file_size_reg    <= cfg_data;
                default:             base_address_reg <= base_address_reg;
            endcase
        end
    end

    // block total = ceil(size / payload), zero for an empty image
    assign prod = {33'd0, file_size_reg - 32'd1} * {32'd0, DIV_M[32:0]};

    always_ff @(posedge clk)
    begin
        quot_reg    <= 32'(prod >> (32 + DIV_SH));
        fs_zero_reg <= (file_size_reg == 32'd0);
    end

    assign total = fs_zero_reg ? 32'd0 : quot_reg + 32'd1;

    // input side
    assign accept = in_valid && !in_stall;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            word_masked[8*i +: 8] = (4'(i) < valid_bytes) ? data_word[8*i +: 8] : 8'd0;
        end
    end

    always_comb
    begin
        eff_idx   = started_reg ? idx_reg : '0;
        eff_num   = started_reg ? num_reg : '0;
        eff_addr  = started_reg ? addr_reg : base_address_reg;
        count_new = CNT_W'(eff_idx) + CNT_W'(1);
        close     = (count_new == CNT_W'(PAYLOAD_WORDS)) || end_of_file;

        started_next = started_reg;
        idx_next     = idx_reg;
        bank_next    = bank_reg;
        num_next     = num_reg;
        addr_next    = addr_reg;
        if (accept)
        begin
            if (close)
            begin
                started_next = !end_of_file;
                idx_next     = '0;
                bank_next    = !bank_reg;
                num_next     = eff_num + 24'd1;
                addr_next    = eff_addr + 32'(PAYLOAD_BYTES);
            end
            else
            begin
                started_next = 1'b1;
                idx_next     = IDX_W'(count_new);
                num_next     = eff_num;
                addr_next    = eff_addr;
            end
        end

        req.hdr   = accept && (eff_idx == '0);
        req.flush = accept && close;
        req.addr  = eff_addr;
        req.num   = eff_num;
        req.count = count_new;
        req.bank  = bank_reg;
        req.eof   = end_of_file;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            idx_reg     <= '0;
            bank_reg    <= 1'b0;
            num_reg     <= '0;
            addr_reg    <= '0;
        end
        else
        begin
            started_reg <= started_next;
            idx_reg     <= idx_next;
            bank_reg    <= bank_next;
            num_reg     <= num_next;
            addr_reg    <= addr_next;
        end
    end

    // two-bank payload buffer
    ufbf_ram #(
        .WIDTH (64),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (accept),
        .waddr ({bank_reg, eff_idx}),
        .wdata (word_masked),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ufbf_seq #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .family_id  (family_id_reg),
        .total      (total),
        .flush_busy (in_stall),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .block_word (block_word),
        .block_end  (block_end),
        .stream_end (stream_end)
    );

endmodule

// ===== src/ufbf_checker.sv =====
// ----------------------------------------------------------------------------
// ufbf_checker
// Port-level checks of the UF2 block framer, bound to the top level.
// ----------------------------------------------------------------------------
module ufbf_checker
    import ufbf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] block_word,
    input logic        block_end,
    input logic        stream_end
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(block_word)
            && $stable(block_end) && $stable(stream_end))
        else $error("output beat changed while stalled");

    // stream end only on the closing word of a block
    a_stream_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_end |-> block_end)
        else $error("stream_end without block_end");

    // closing word carries the end magic over a zero low half
    a_end_magic: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && block_end |-> block_word == {MAGIC_END, 32'd0})
        else $error("block end word is not the end magic");

endmodule

bind uf2_block_framer ufbf_checker u_ufbf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .block_word (block_word),
    .block_end  (block_end),
    .stream_end (stream_end)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of uf2_block_framer. Image beats go in as short directed streams
// and then as random streams under changing register settings and idle
// and stall patterns. A behavioral framer in the bench builds every block
// word the beats should produce. Each word leaving the block is checked
// against the oldest of them, field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import ufbf_pkg::*;

    localparam int PAYLOAD_BYTES  = UFBF_PAYLOAD_BYTES;
    localparam int PAYLOAD_WORDS  = PAYLOAD_BYTES / 8;
    localparam int TAIL_WORDS     = BLOCK_WORDS - HEADER_WORDS - PAYLOAD_WORDS;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [63:0] word;
        logic        blk_end;
        logic        strm_end;
    } block_beat_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        end_of_file;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] block_word;
    logic        block_end;
    logic        stream_end;

    // register copies and framing state of the bench's own framer
    logic [31:0] reg_base;
    logic [31:0] reg_family;
    logic [31:0] reg_file_size;
    logic [23:0] cur_block;
    logic [31:0] cur_addr;
    int          fill;
    logic        streaming;
    logic [63:0] payload [PAYLOAD_WORDS];

    block_beat_t block_words_due [$];
    block_beat_t due;

    int idle_pct;
    int stall_pct;
    int beats_sent;
    int words_seen;
    int mismatches;
    int quiet_cycles;

    uf2_block_framer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_word   (data_word),
        .valid_bytes (valid_bytes),
        .end_of_file (end_of_file),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .block_word  (block_word),
        .block_end   (block_end),
        .stream_end  (stream_end)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch in %s at output word %0d: got %h, want %h",
                 what, words_seen, got, want);
        mismatches++;
    endtask

    task automatic push_word(input logic [63:0] w, input logic be, input logic se);
        block_beat_t b;
        b.word     = w;
        b.blk_end  = be;
        b.strm_end = se;
        block_words_due.push_back(b);
    endtask

    // builds the block words that one accepted image beat releases
    task automatic frame_beat(input logic [63:0] w, input logic [3:0] vb,
                              input logic eof);
        logic [63:0] masked;
        logic [32:0] rounded;
        logic [31:0] total;
        int          nbytes;
        nbytes = (vb > 4'd8) ? 8 : int'(vb);
        masked = (nbytes == 8) ? w : (w & ((64'd1 << (8 * nbytes)) - 64'd1));
        if (!streaming)
        begin
            cur_addr  = reg_base;
            cur_block = '0;
            fill      = 0;
            streaming = 1'b1;
        end
        if (fill == 0)
        begin
            rounded = {1'b0, reg_file_size} + 33'(PAYLOAD_BYTES - 1);
            total   = 32'(rounded / 33'(PAYLOAD_BYTES));
            push_word({MAGIC_START1, MAGIC_START0}, 1'b0, 1'b0);
            push_word({cur_addr, FLAG_FAMILY}, 1'b0, 1'b0);
            push_word({8'h00, cur_block, 32'(PAYLOAD_BYTES)}, 1'b0, 1'b0);
            push_word({reg_family, total}, 1'b0, 1'b0);
        end
        if (fill < PAYLOAD_WORDS)
            payload[fill] = masked;
        fill++;
        if (fill >= PAYLOAD_WORDS || eof)
        begin
            for (int i = 0; i < PAYLOAD_WORDS; i++)
                push_word((i < fill) ? payload[i] : 64'd0, 1'b0, 1'b0);
            for (int i = 0; i + 1 < TAIL_WORDS; i++)
                push_word(64'd0, 1'b0, 1'b0);
            push_word({MAGIC_END, 32'h0}, 1'b1, eof);
            cur_block = cur_block + 24'd1;
            cur_addr  = cur_addr + 32'(PAYLOAD_BYTES);
            fill      = 0;
            for (int i = 0; i < PAYLOAD_WORDS; i++)
                payload[i] = '0;
            if (eof)
                streaming = 1'b0;
        end
    endtask

    // valid stays high after the beat; whoever spends time next lowers it
    task automatic send_beat(input logic [63:0] w, input logic [3:0] vb,
                             input logic eof);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_word   <= w;
        valid_bytes <= vb;
        end_of_file <= eof;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
        frame_beat(w, vb, eof);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (block_words_due.size() != 0);
        // a beat inside a block releases nothing, so give the pipe time to settle
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_BASE_ADDRESS:    reg_base      = value;
            CFG_FAMILY_ID:       reg_family    = value;
            CFG_FILE_SIZE_BYTES: reg_file_size = value;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [31:0] base, input logic [31:0] family,
                                input logic [31:0] size);
        wait_drained();
        write_reg(CFG_BASE_ADDRESS, base);
        write_reg(CFG_FAMILY_ID, family);
        write_reg(CFG_FILE_SIZE_BYTES, size);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_reg_value();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'hFFFF_FF00 | ($urandom() & 32'h0000_00F8);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_stream(input int len);
        logic [3:0] vb;
        for (int k = 0; k < len; k++)
        begin
            vb = ($urandom_range(0, 9) < 8) ? 4'd8 : 4'($urandom_range(0, 15));
            send_beat({$urandom(), $urandom()}, vb, k == len - 1);
        end
    endtask

    // reset register values, end of file on the first beat of a block
    task automatic test_reset_defaults();
        idle_pct  = 0;
        stall_pct = 0;
        send_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
        send_beat(64'h0000_0000_0000_0000, 4'd8, 1'b1);
    endtask

    // every valid_bytes value, zero and out-of-range counts included
    task automatic test_byte_masking();
        program_regs(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
        for (int vb = 0; vb < 16; vb++)
            send_beat((vb % 2) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom(), $urandom()},
                      4'(vb), vb == 15);
    endtask

    // sender holds off mid-block until every pending word has come out
    task automatic test_mid_block_pause();
        program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_stream(3);
        send_beat(64'h0123_4567_89AB_CDEF, 4'd8, 1'b0);
        send_beat(64'hFEDC_BA98_7654_3210, 4'd3, 1'b0);
        wait_drained();
        send_beat(64'hA5A5_5A5A_A5A5_5A5A, 4'd8, 1'b0);
        send_beat(64'h5A5A_A5A5_5A5A_A5A5, 4'd7, 1'b1);
    endtask

    // target address crosses 2^32 between two blocks
    task automatic test_address_wrap();
        program_regs(32'hFFFF_FF00, 32'h5775_5A57, 32'h0000_2800);
        idle_pct  = 24;
        stall_pct = 24;
        send_stream(40);
    endtask

    task automatic test_random_streams();
        int idle_by_phase  [4] = '{0, 67, 0, 24};
        int stall_by_phase [4] = '{0, 0, 67, 24};
        int phase_end;
        int len;
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = idle_by_phase[ph];
            stall_pct = stall_by_phase[ph];
            phase_end = beats_sent + 30;
            while (beats_sent < phase_end)
            begin
                if ($urandom_range(0, 2) == 0)
                    program_regs(pick_reg_value(), pick_reg_value(), pick_reg_value());
                case ($urandom_range(0, 9))
                    0: len = PAYLOAD_WORDS;
                    1: len = PAYLOAD_WORDS + 1;
                    2: len = 2 * PAYLOAD_WORDS;
                    3: len = 1;
                    default: len = $urandom_range(2, 48);
                endcase
                send_stream(len);
            end
        end
    endtask

    // output side: check each word taken, then pick next cycle's stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (block_words_due.size() == 0)
                report_mismatch("block_word, none expected", block_word, 64'd0);
            else
            begin
                due = block_words_due.pop_front();
                if (block_word !== due.word)
                    report_mismatch("block_word", block_word, due.word);
                if (block_end !== due.blk_end)
                    report_mismatch("block_end", 64'(block_end), 64'(due.blk_end));
                if (stream_end !== due.strm_end)
                    report_mismatch("stream_end", 64'(stream_end), 64'(due.strm_end));
            end
            words_seen++;
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no beat moved in %0d cycles", WATCHDOG_LIMIT);
            $display("** uf2_block_framer: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_BASE_ADDRESS;
        cfg_data      = '0;
        in_valid      = 1'b0;
        data_word     = '0;
        valid_bytes   = '0;
        end_of_file   = 1'b0;
        out_stall     = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        beats_sent    = 0;
        words_seen    = 0;
        mismatches    = 0;
        quiet_cycles  = 0;
        reg_base      = BASE_ADDRESS_RESET;
        reg_family    = FAMILY_ID_RESET;
        reg_file_size = '0;
        cur_block     = '0;
        cur_addr      = '0;
        fill          = 0;
        streaming     = 1'b0;
        for (int i = 0; i < PAYLOAD_WORDS; i++)
            payload[i] = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_byte_masking();
        test_mid_block_pause();
        test_address_wrap();
        test_random_streams();
        wait_drained();

        if (mismatches == 0)
            $display("** uf2_block_framer: PASSED **");
        else
            $display("** uf2_block_framer: FAILED **");
        $finish;
    end

endmodule
